@@ rtl/omw_pkg.sv @@
// shared types, constants and the quarter-wave sine table for the omni wheel mixer
// no dependencies
package omw_pkg;

  localparam int OmwNumMotors = 4;
  localparam int OmwMaxMotors = 8;

  // input and output beat tdata widths
  localparam int InTdataW  = 40;
  localparam int OutTdataW = 16;

  // config register indexes
  localparam logic [1:0] RegGainP = 2'd0;
  localparam logic [1:0] RegGainI = 2'd1;
  localparam logic [1:0] RegGainD = 2'd2;

  localparam longint unsigned OneQ30 = 64'd1073741824;
  localparam longint unsigned PiQ30  = 64'd3373259426;

  localparam int SinEntries = 181;

  typedef logic [15:0] sin_tab_t [0:SinEntries-1];

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_ERR_KP,
    MUL_SUM_KI,
    MUL_DER_KD,
    MUL_TERM_SPD,
    MUL_PID_MAG
  } omw_mul_sel_e;

  typedef struct packed {
    logic         ld;
    omw_mul_sel_e mul_sel;
    logic         acc_ld;
    logic         acc_add;
    logic         pid_ld;
    logic         idx_rst;
    logic         mag_rst;
    logic         sine_wr;
    logic         idx_inc;
    logic         t1_ld;
    logic         num_ld;
    logic         div_step;
    logic         out_ld;
  } omw_cmd_t;

  typedef struct packed {
    logic is_move;
    logic idx_last;
    logic div_last;
    logic out_free;
  } omw_stat_t;

  // quarter-wave sine in q15, argument in half degrees 0..180
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t        tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    for (int q = 0; q < SinEntries; q++) begin
      x  = (longint'(q) * PiQ30) / 360;
      x2 = (x * x) >> 30;
      t  = OneQ30;
      t  = OneQ30 - ((x2 * t) >> 30) / 156;
      t  = OneQ30 - ((x2 * t) >> 30) / 110;
      t  = OneQ30 - ((x2 * t) >> 30) / 72;
      t  = OneQ30 - ((x2 * t) >> 30) / 42;
      t  = OneQ30 - ((x2 * t) >> 30) / 20;
      t  = OneQ30 - ((x2 * t) >> 30) / 6;
      t  = (((x * t) >> 30) + 64'd16384) >> 15;
      tab[q] = t[15:0];
    end
    return tab;
  endfunction

  localparam sin_tab_t SinTab = build_sin_tab();

endpackage

@@ rtl/omw_datapath.sv @@
// datapath of the omni wheel mixer: pid state, shared multiplier, sine, divider, output beat
// depends on omw_pkg
module omw_datapath import omw_pkg::*; #(
  parameter int NumMotors = OmwNumMotors
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  omw_cmd_t             cmd_i,
  output omw_stat_t            stat_o,
  input  logic                 in_cmd_i,
  input  logic [8:0]           in_target_i,
  input  logic signed [8:0]    in_speed_i,
  input  logic signed [15:0]   in_err_i,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           out_motor_o,
  output logic [7:0]           out_duty_o,
  output logic                 out_forward_o,
  output logic                 out_last_o
);

  localparam int IdxW  = $clog2(NumMotors);
  localparam int WaStep = 360 / NumMotors;
  localparam logic [9:0] WaInit = 10'(WaStep);
  localparam logic [9:0] WaInc  = 10'(2 * WaStep);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(NumMotors - 1);

  // gains and pid state
  logic signed [15:0] kp_q, ki_q, kd_q;
  logic signed [31:0] esum_q, esum_d;
  logic signed [15:0] prev_q;

  // latched command
  logic               move_q;
  logic [8:0]         tgt_q;
  logic [8:0]         aspd_q;
  logic signed [15:0] err_q;
  logic signed [16:0] der_q;

  // multiplier and pid accumulation
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] prod_q;
  logic signed [49:0] acc_q;
  logic signed [25:0] pid_q;

  // wheel sine terms
  logic signed [17:0] term_q [NumMotors];
  logic [IdxW-1:0]    idx_q;
  logic [9:0]         wa_q;
  logic [15:0]        mag_q;

  // divider
  logic signed [38:0] t1_q;
  logic [42:0]        rem_q;
  logic [35:0]        trial_q;
  logic               pos_q;
  logic               sat_q;
  logic [7:0]         quo_q;
  logic [3:0]         dcnt_q;

  logic [2:0]         out_motor_q;
  logic [7:0]         out_duty_q;
  logic               out_fwd_q;
  logic               out_last_q;
  logic               out_valid_q;

  logic               use_scale;
  logic signed [32:0] sum_ext;

  assign use_scale = move_q && (aspd_q != 9'd0) && (mag_q != 16'd0);

  // saturating integral update
  assign sum_ext = 33'(esum_q) + 33'(in_err_i);
  always_comb begin
    if (sum_ext > 33'sd2147483647) begin
      esum_d = 32'sh7fffffff;
    end else if (sum_ext < -33'sd2147483648) begin
      esum_d = 32'sh80000000;
    end else begin
      esum_d = sum_ext[31:0];
    end
  end

  // operand select
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_ERR_KP: begin
        mul_a = 33'(err_q);
        mul_b = 18'(kp_q);
      end
      MUL_SUM_KI: begin
        mul_a = 33'(esum_q);
        mul_b = 18'(ki_q);
      end
      MUL_DER_KD: begin
        mul_a = 33'(der_q);
        mul_b = 18'(kd_q);
      end
      MUL_TERM_SPD: begin
        mul_a = use_scale ? 33'(term_q[idx_q]) : 33'sd0;
        mul_b = $signed({9'd0, aspd_q});
      end
      MUL_PID_MAG: begin
        mul_a = 33'(pid_q);
        mul_b = use_scale ? $signed({2'd0, mag_q}) : 18'sd1;
      end
      default: begin
        mul_a = 33'sd0;
        mul_b = 18'sd0;
      end
    endcase
  end

  // wheel sine: relative angle in half degrees, folded to a quarter wave
  logic [8:0]         tgt_mod;
  logic signed [10:0] h_raw;
  logic [9:0]         h;
  logic [7:0]         qarg;
  logic               qneg;
  logic signed [17:0] sin_val;
  logic [15:0]        sin_abs;

  always_comb begin
    tgt_mod = (tgt_q >= 9'd360) ? tgt_q - 9'd360 : tgt_q;
    h_raw   = $signed({1'b0, tgt_mod, 1'b0}) - $signed({1'b0, wa_q});
    h       = (h_raw < 0) ? 10'(h_raw + 11'sd720) : h_raw[9:0];
    if (h < 10'd180) begin
      qarg = h[7:0];
      qneg = 1'b0;
    end else if (h < 10'd360) begin
      qarg = 8'(10'd360 - h);
      qneg = 1'b0;
    end else if (h < 10'd540) begin
      qarg = 8'(h - 10'd360);
      qneg = 1'b1;
    end else begin
      qarg = 8'(10'd720 - h);
      qneg = 1'b1;
    end
    sin_abs = SinTab[qarg];
    sin_val = qneg ? -$signed({2'd0, sin_abs}) : $signed({2'd0, sin_abs});
  end

  // numerator of the drive quotient
  logic signed [42:0] num;
  assign num = 43'(t1_q) - 43'(prod_q);

  // restoring division step
  logic rem_ge;
  assign rem_ge = rem_q >= 43'(trial_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      esum_q      <= '0;
      prev_q      <= '0;
      idx_q       <= '0;
      wa_q        <= WaInit;
      mag_q       <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegGainP: kp_q <= cfg_data_i;
          RegGainI: ki_q <= cfg_data_i;
          RegGainD: kd_q <= cfg_data_i;
          default: ;
        endcase
        if (cfg_index_i == RegGainP || cfg_index_i == RegGainI ||
            cfg_index_i == RegGainD) begin
          esum_q <= '0;
          prev_q <= '0;
        end
      end
      if (cmd_i.ld) begin
        esum_q <= esum_d;
        prev_q <= in_err_i;
      end
      if (cmd_i.mag_rst) begin
        mag_q <= '0;
      end else if (cmd_i.sine_wr && sin_abs > mag_q) begin
        mag_q <= sin_abs;
      end
      if (cmd_i.idx_rst) begin
        idx_q <= '0;
        wa_q  <= WaInit;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
        wa_q  <= wa_q + WaInc;
      end
      if (cmd_i.num_ld) begin
        dcnt_q <= 4'd8;
      end else if (cmd_i.div_step && dcnt_q != 4'd0) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      move_q <= ~in_cmd_i;
      tgt_q  <= in_target_i;
      aspd_q <= in_speed_i[8] ? 9'(-in_speed_i) : in_speed_i;
      err_q  <= in_err_i;
      der_q  <= 17'(in_err_i) - 17'(prev_q);
    end
    prod_q <= 51'(mul_a * mul_b);
    if (cmd_i.acc_ld) begin
      acc_q <= 50'(prod_q);
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + 50'(prod_q);
    end
    if (cmd_i.pid_ld) begin
      if (acc_q > 50'sd16777216) begin
        pid_q <= 26'sd16777216;
      end else if (acc_q < -50'sd16777216) begin
        pid_q <= -26'sd16777216;
      end else begin
        pid_q <= acc_q[25:0];
      end
    end
    if (cmd_i.sine_wr) begin
      term_q[idx_q] <= sin_val;
    end
    if (cmd_i.t1_ld) begin
      t1_q <= 39'(prod_q) <<< 12;
    end
    if (cmd_i.num_ld) begin
      rem_q   <= num[42] ? 43'(-num) : num;
      pos_q   <= !num[42] && (num != 43'sd0);
      trial_q <= use_scale ? {mag_q, 20'd0} : 36'd1048576;
      quo_q   <= '0;
      sat_q   <= 1'b0;
    end else if (cmd_i.div_step) begin
      trial_q <= trial_q >> 1;
      if (dcnt_q == 4'd8) begin
        sat_q <= rem_ge;
      end else if (rem_ge) begin
        rem_q              <= rem_q - 43'(trial_q);
        quo_q[dcnt_q[2:0]] <= 1'b1;
      end
    end
    if (cmd_i.out_ld) begin
      out_motor_q <= 3'(idx_q);
      out_duty_q  <= sat_q ? 8'd255 : quo_q;
      out_fwd_q   <= pos_q && (sat_q || quo_q != 8'd0);
      out_last_q  <= (idx_q == IdxLast);
    end
  end

  assign stat_o.is_move  = move_q;
  assign stat_o.idx_last = (idx_q == IdxLast);
  assign stat_o.div_last = (dcnt_q == 4'd0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_motor_o   = out_motor_q;
  assign out_duty_o    = out_duty_q;
  assign out_forward_o = out_fwd_q;
  assign out_last_o    = out_last_q;

endmodule

@@ rtl/omw_ctrl.sv @@
// sequencer of the omni wheel mixer: pid steps, sine sweep, per-wheel divide and emit
// depends on omw_pkg
module omw_ctrl import omw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  omw_stat_t stat_i,
  output omw_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_PID_SUM,
    ST_PID_CLAMP,
    ST_SINE,
    ST_W_MUL_S,
    ST_W_MUL_P,
    ST_W_NUM,
    ST_W_DIV,
    ST_W_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mul_sel = MUL_ERR_KP;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld = 1'b1;
          state_d  = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        cmd_o.mul_sel = MUL_ERR_KP;
        state_d       = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd_o.mul_sel = MUL_SUM_KI;
        cmd_o.acc_ld  = 1'b1;
        state_d       = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd_o.mul_sel = MUL_DER_KD;
        cmd_o.acc_add = 1'b1;
        state_d       = ST_PID_SUM;
      end
      ST_PID_SUM: begin
        cmd_o.acc_add = 1'b1;
        state_d       = ST_PID_CLAMP;
      end
      ST_PID_CLAMP: begin
        cmd_o.pid_ld  = 1'b1;
        cmd_o.idx_rst = 1'b1;
        cmd_o.mag_rst = 1'b1;
        state_d       = stat_i.is_move ? ST_SINE : ST_W_MUL_S;
      end
      ST_SINE: begin
        cmd_o.sine_wr = 1'b1;
        if (stat_i.idx_last) begin
          cmd_o.idx_rst = 1'b1;
          state_d       = ST_W_MUL_S;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_W_MUL_S: begin
        cmd_o.mul_sel = MUL_TERM_SPD;
        state_d       = ST_W_MUL_P;
      end
      ST_W_MUL_P: begin
        cmd_o.mul_sel = MUL_PID_MAG;
        cmd_o.t1_ld   = 1'b1;
        state_d       = ST_W_NUM;
      end
      ST_W_NUM: begin
        cmd_o.num_ld = 1'b1;
        state_d      = ST_W_DIV;
      end
      ST_W_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_W_EMIT;
        end
      end
      ST_W_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          if (stat_i.idx_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_W_MUL_S;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/omni_wheel_mixer_with_pid.sv @@
// omni wheel mixer with heading pid: one command beat in, one drive beat per wheel out
// the pid runs three multiplies, a sum and a clamp; a move command then sweeps the sine over
// every wheel, then each wheel runs two multiplies, numerator, 9-step restoring divide, emit;
// emit waits for a free output; one shared multiplier and a bit-serial divider do the work
// one command at a time; the next command beat is taken once the last wheel beat is registered
// reset: asynchronous active low, gains and pid state cleared, no clearing pass
module omni_wheel_mixer_with_pid import omw_pkg::*; #(
  parameter int NumMotors = OmwNumMotors
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command beat
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: target_angle[8:0], speed[17:9], heading_error[33:18], zero pad [39:34]
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // tuser: cmd (0 move, 1 align)
  input  logic                 s_axis_tuser,
  // wheel drive beat
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: motor_index[2:0], duty[10:3], forward[11], zero pad [15:12]
  output logic [OutTdataW-1:0] m_axis_tdata,
  output logic                 m_axis_tlast,
  // gain writes, always ready
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  omw_cmd_t  cmd;
  omw_stat_t stat;

  logic [2:0] out_motor;
  logic [7:0] out_duty;
  logic       out_fwd;

  assign cfg_ready_o = 1'b1;

  // sequencer
  omw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // pid, sine sweep, divider and output register
  omw_datapath #(
    .NumMotors (NumMotors)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_cmd_i      (s_axis_tuser),
    .in_target_i   (s_axis_tdata[8:0]),
    .in_speed_i    (s_axis_tdata[17:9]),
    .in_err_i      (s_axis_tdata[33:18]),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_motor_o   (out_motor),
    .out_duty_o    (out_duty),
    .out_forward_o (out_fwd),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, out_fwd, out_duty, out_motor};

endmodule
